### hw/rtl/ring_ordered_finger_table_core_assert.svh
// ----------------------------------------------------------------------------
// ring_ordered_finger_table_core_assert
// Assertion macros for the finger table core.
// ----------------------------------------------------------------------------
`ifndef RING_ORDERED_FINGER_TABLE_CORE_ASSERT_SVH
`define RING_ORDERED_FINGER_TABLE_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ROFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ROFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/roft_pkg.sv
// ----------------------------------------------------------------------------
// roft_pkg
// Types and constants shared by the finger table core and its parts.
// ----------------------------------------------------------------------------
package roft_pkg;

  localparam int TableDepth = 16;
  localparam int IdBits     = 32;
  localparam int CntBits    = $clog2(TableDepth + 1);
  localparam int IdxBits    = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] key_id;
    logic [31:0] time_now;
  } in_word_t;

  typedef struct packed {
    logic [31:0] lookup_pred;
    logic [31:0] lookup_succ;
    logic        pred_changed;
    logic [31:0] old_pred;
    logic [31:0] node_successor;
    logic [31:0] node_predecessor;
    logic [4:0]  entry_count;
  } out_word_t;

  // Command passed from the front end to the table engine.
  typedef struct packed {
    logic              opcode;
    logic [IdBits-1:0] key;
    logic [31:0]       time_now;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_PLACE
  } eng_state_t;

  // Strictly inside clockwise interval (a,b); a == b means x != a.
  function automatic logic ring_between(logic [IdBits-1:0] x, logic [IdBits-1:0] a,
                                        logic [IdBits-1:0] b);
    logic r;
    if (a == b)     r = (x != a);
    else if (a < b) r = (a < x) && (x < b);
    else            r = (a < x) || (x < b);
    return r;
  endfunction

endpackage

### hw/rtl/ring_ordered_finger_table_core.sv
// ----------------------------------------------------------------------------
// ring_ordered_finger_table_core
// Ring-ordered peer table with least-recently-used eviction and lookup.
// ----------------------------------------------------------------------------
// Channel   Ports                        Handshake
// input     in_word                      start high, busy low
// result    out_word                     out_strobe, one cycle
// config    cfg_we, cfg_wdata            cfg_we high
//
// A lookup, refresh or own-id insert is answered from the engine's place step;
// a new insert is answered from the shift-insert step that follows the place step.
// A full table evicts the oldest entry in the place step, ahead of the insert.
// Reset empties the table at once; no clearing pass is needed.
// The receiver cannot stall; busy holds off start while a word is queued.
// ----------------------------------------------------------------------------
`include "ring_ordered_finger_table_core_assert.svh"
module ring_ordered_finger_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  roft_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output roft_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);

  logic [31:0]    own_r;
  logic           cmd_valid, cmd_take, eng_idle;
  roft_pkg::cmd_t cmd;

  // Own node id register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= '0;
    end else if (cfg_we) begin
      own_r <= cfg_wdata;
    end
  end

  roft_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  roft_engine u_engine (
    .clk(clk), .rst_n(rst_n), .own_id(own_r), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take), .out_strobe(out_strobe), .out_word(out_word),
    .eng_idle(eng_idle)
  );

  `ROFT_ASSERT_IMP(a_take_needs_word, clk, rst_n, cmd_take, cmd_valid)
  `ROFT_ASSERT_IMP(a_count_range, clk, rst_n, out_strobe, out_word.entry_count <= 5'(roft_pkg::TableDepth))
  `ROFT_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `ROFT_ASSERT_IMP(a_idle_front_empty, clk, rst_n, eng_idle, !busy)

endmodule

### hw/rtl/roft_front.sv
// ----------------------------------------------------------------------------
// roft_front
// Accepts command words and holds them in a one-entry queue for the engine.
// ----------------------------------------------------------------------------
module roft_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  roft_pkg::in_word_t in_word,
  output logic               busy,
  output logic               cmd_valid,
  output roft_pkg::cmd_t     cmd,
  input  logic               cmd_take
);

  logic           full_r, full_nxt;
  roft_pkg::cmd_t cmd_r;

  // The queue slot is busy until the engine takes the word.
  assign busy      = full_r;
  assign cmd_valid = full_r;
  assign cmd       = cmd_r;

  always_comb begin
    full_nxt = full_r;
    if (cmd_take) full_nxt = 1'b0;
    if (start && !busy) full_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // Classify and capture the word; the key is cut to the id width.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r.opcode   <= in_word.opcode;
      cmd_r.key      <= roft_pkg::IdBits'(in_word.key_id);
      cmd_r.time_now <= in_word.time_now;
    end
  end

endmodule

### hw/rtl/roft_engine.sv
// ----------------------------------------------------------------------------
// roft_engine
// Holds the ring-ordered table and carries out insert and lookup commands.
// ----------------------------------------------------------------------------
module roft_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         own_id,
  input  logic                cmd_valid,
  input  roft_pkg::cmd_t      cmd,
  output logic                cmd_take,
  output logic                out_strobe,
  output roft_pkg::out_word_t out_word,
  output logic                eng_idle
);

  localparam int D = roft_pkg::TableDepth;
  localparam int W = roft_pkg::IdBits;
  localparam int C = roft_pkg::CntBits;
  localparam int X = roft_pkg::IdxBits;

  logic [W-1:0]  ids_r  [D];
  logic [31:0]   use_r  [D];
  logic [C-1:0]  cnt_r, cnt_nxt;
  roft_pkg::eng_state_t st_r, st_nxt;
  roft_pkg::cmd_t       c_r;
  logic                 pc_r, pc_nxt;
  logic [W-1:0]         op_r, op_nxt;
  logic                 strobe_r, strobe_nxt;
  roft_pkg::out_word_t  ow_r, ow_nxt;

  logic [W-1:0] own;
  logic [W-1:0] tpred;
  logic [D-1:0] hit;
  logic [D-1:0] is_min;
  logic [X-1:0] hit_idx, min_idx, pos;
  logic         any_hit;
  logic [D-1:0] gap;
  logic [W-1:0] lk_pred, lk_succ;
  logic [C-1:0] pos_cnt;

  logic         do_shift_ins, do_remove, do_refresh;
  logic [X-1:0] act_idx;

  assign own   = W'(own_id);
  assign tpred = (cnt_r != '0) ? ids_r[X'(cnt_r - C'(1))] : own;
  assign eng_idle = (st_r == roft_pkg::ST_IDLE) && !cmd_valid;
  assign out_strobe = strobe_r;
  assign out_word   = ow_r;

  // Parallel compares over all entries: hits, oldest candidates, gap test.
  always_comb begin
    hit = '0; is_min = '0; gap = '0;
    for (int i = 0; i < D; i++) begin
      if (C'(i) < cnt_r) begin
        hit[i] = (ids_r[i] == c_r.key);
        is_min[i] = 1'b1;
        for (int j = 0; j < D; j++) begin
          if (C'(j) < cnt_r) begin
            if (use_r[j] < use_r[i]) is_min[i] = 1'b0;
            if (j < i && use_r[j] == use_r[i]) is_min[i] = 1'b0;
          end
        end
        if (i == 0) gap[i] = roft_pkg::ring_between(c_r.key, own, ids_r[0]) ||
                             (ids_r[0] == c_r.key);
        else        gap[i] = roft_pkg::ring_between(c_r.key, ids_r[i-1], ids_r[i]) ||
                             (ids_r[i] == c_r.key);
      end
    end
  end

  // Priority encoders over the compare vectors.
  always_comb begin
    hit_idx = '0; min_idx = '0; pos = X'(0); pos_cnt = cnt_r; any_hit = |hit;
    for (int i = D - 1; i >= 0; i--) begin
      if (hit[i])    hit_idx = X'(i);
      if (is_min[i]) min_idx = X'(i);
    end
    for (int i = D - 1; i >= 0; i--) begin
      if (gap[i]) pos_cnt = C'(i);
    end
    pos = X'(pos_cnt);
    lk_pred = own; lk_succ = own;
    if (cnt_r != '0) begin
      if (pos_cnt == cnt_r) begin
        lk_pred = tpred;
        lk_succ = own;
      end else begin
        lk_succ = ids_r[X'(pos_cnt)];
        lk_pred = (pos_cnt == '0) ? own : ids_r[X'(pos_cnt - C'(1))];
      end
    end
  end

  // Sequencer: idle takes; place answers or evicts the oldest; evict inserts.
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; pc_nxt = pc_r; op_nxt = op_r;
    strobe_nxt = 1'b0; ow_nxt = ow_r; cmd_take = 1'b0;
    do_shift_ins = 1'b0; do_remove = 1'b0; do_refresh = 1'b0; act_idx = '0;
    case (st_r)
      roft_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          st_nxt = roft_pkg::ST_PLACE;
        end
      end
      roft_pkg::ST_PLACE: begin
        if (c_r.opcode == roft_pkg::OP_LOOKUP) begin
          ow_nxt = '0;
          ow_nxt.lookup_pred = 32'(lk_pred);
          ow_nxt.lookup_succ = 32'(lk_succ);
          ow_nxt.node_successor = 32'((cnt_r != '0) ? ids_r[0] : own);
          ow_nxt.node_predecessor = 32'(tpred);
          ow_nxt.entry_count = 5'(cnt_r);
          strobe_nxt = 1'b1;
          st_nxt = roft_pkg::ST_IDLE;
        end else if (c_r.key == own) begin
          ow_nxt = '0;
          ow_nxt.node_successor = 32'((cnt_r != '0) ? ids_r[0] : own);
          ow_nxt.node_predecessor = 32'(tpred);
          ow_nxt.entry_count = 5'(cnt_r);
          strobe_nxt = 1'b1;
          st_nxt = roft_pkg::ST_IDLE;
        end else begin
          pc_nxt = roft_pkg::ring_between(c_r.key, tpred, own);
          op_nxt = pc_nxt ? tpred : '0;
          if (any_hit) begin
            do_refresh = 1'b1; act_idx = hit_idx;
            ow_nxt = '0;
            ow_nxt.pred_changed = pc_nxt;
            ow_nxt.old_pred = 32'(op_nxt);
            ow_nxt.node_successor = 32'(ids_r[0]);
            ow_nxt.node_predecessor = 32'(tpred);
            ow_nxt.entry_count = 5'(cnt_r);
            strobe_nxt = 1'b1;
            st_nxt = roft_pkg::ST_IDLE;
          end else if (cnt_r >= C'(D)) begin
            do_remove = 1'b1; act_idx = min_idx;
            cnt_nxt = cnt_r - C'(1);
            st_nxt = roft_pkg::ST_EVICT;
          end else begin
            st_nxt = roft_pkg::ST_EVICT;
          end
        end
      end
      roft_pkg::ST_EVICT: begin
        // Shift insert at the gap found for the key.
        do_shift_ins = 1'b1; act_idx = pos;
        cnt_nxt = cnt_r + C'(1);
        ow_nxt = '0;
        ow_nxt.pred_changed = pc_r;
        ow_nxt.old_pred = 32'(op_r);
        ow_nxt.node_successor = 32'((pos == '0) ? c_r.key : ids_r[0]);
        ow_nxt.node_predecessor = 32'((pos_cnt == cnt_r) ? c_r.key : tpred);
        ow_nxt.entry_count = 5'(cnt_nxt);
        strobe_nxt = 1'b1;
        st_nxt = roft_pkg::ST_IDLE;
      end
      default: st_nxt = roft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= roft_pkg::ST_IDLE;
      cnt_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers and table storage.
  always_ff @(posedge clk) begin
    pc_r <= pc_nxt;
    op_r <= op_nxt;
    ow_r <= ow_nxt;
    if (cmd_take) c_r <= cmd;
    for (int i = 0; i < D; i++) begin
      if (do_refresh && X'(i) == act_idx) use_r[i] <= c_r.time_now;
      if (do_remove && X'(i) >= act_idx && i + 1 < D) begin
        ids_r[i] <= ids_r[i+1];
        use_r[i] <= use_r[i+1];
      end
      if (do_shift_ins) begin
        if (X'(i) == act_idx) begin
          ids_r[i] <= c_r.key;
          use_r[i] <= c_r.time_now;
        end else if (X'(i) > act_idx && i > 0) begin
          ids_r[i] <= ids_r[i-1];
          use_r[i] <= use_r[i-1];
        end
      end
    end
  end

endmodule

### tb/sv/tb_ring_ordered_finger_table_core.sv
// ----------------------------------------------------------------------------
// tb_ring_ordered_finger_table_core
// Drives insert and lookup words into the finger table core, predicts each
// result word with a behavioural copy of the ring-ordered table, and compares
// every strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_ring_ordered_finger_table_core;

  localparam int DEPTH = roft_pkg::TableDepth;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  roft_pkg::in_word_t in_word;
  logic out_strobe;
  roft_pkg::out_word_t out_word;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  ring_ordered_finger_table_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the table as the block should hold it.
  logic [31:0] tbl_id [DEPTH];
  logic [31:0] tbl_use [DEPTH];
  int unsigned tbl_count;
  logic [31:0] own_id;

  roft_pkg::in_word_t pending_words[$];
  roft_pkg::out_word_t expected_words[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned gap_left;
  bit words_done;

  always begin
    #6 clk = ~clk;
  end

  function automatic bit is_between(logic [31:0] x, logic [31:0] a, logic [31:0] b);
    if (a == b) return x != a;
    if (a < b) return (a < x) && (x < b);
    return (a < x) || (x < b);
  endfunction

  function automatic logic [31:0] last_entry();
    return (tbl_count != 0) ? tbl_id[tbl_count - 1] : own_id;
  endfunction

  // Shift entries up from pos and place the new id there.
  function automatic void place_at(int unsigned pos, logic [31:0] id, logic [31:0] t);
    for (int unsigned i = tbl_count; i > pos; i--) begin
      tbl_id[i] = tbl_id[i - 1];
      tbl_use[i] = tbl_use[i - 1];
    end
    tbl_id[pos] = id;
    tbl_use[pos] = t;
    tbl_count++;
  endfunction

  // Work out the result word for one accepted word and update the table.
  function automatic roft_pkg::out_word_t predict_table_word(roft_pkg::in_word_t w);
    roft_pkg::out_word_t r;
    logic [31:0] k;
    logic [31:0] p;
    int unsigned oldest;
    bit found;
    r = '0;
    k = w.key_id;
    if (w.opcode == roft_pkg::OP_INSERT) begin
      if (k != own_id) begin
        p = last_entry();
        if (is_between(k, p, own_id)) begin
          r.pred_changed = 1'b1;
          r.old_pred = p;
        end
        found = 0;
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (!found && tbl_id[i] == k) begin
            tbl_use[i] = w.time_now;
            found = 1;
          end
        end
        if (!found) begin
          if (tbl_count >= DEPTH) begin
            oldest = 0;
            for (int unsigned i = 1; i < tbl_count; i++) begin
              if (tbl_use[i] < tbl_use[oldest]) oldest = i;
            end
            for (int unsigned i = oldest; i + 1 < tbl_count; i++) begin
              tbl_id[i] = tbl_id[i + 1];
              tbl_use[i] = tbl_use[i + 1];
            end
            tbl_count--;
          end
          if (tbl_count == 0 || is_between(k, own_id, tbl_id[0])) begin
            place_at(0, k, w.time_now);
          end else begin
            found = 0;
            for (int unsigned i = 0; i < tbl_count; i++) begin
              if (!found && (i + 1 == tbl_count ||
                             is_between(k, tbl_id[i], tbl_id[i + 1]))) begin
                place_at(i + 1, k, w.time_now);
                found = 1;
              end
            end
          end
        end
      end
    end else begin
      if (tbl_count == 0) begin
        r.lookup_pred = own_id;
        r.lookup_succ = own_id;
      end else if (is_between(k, own_id, tbl_id[0]) || tbl_id[0] == k) begin
        r.lookup_pred = own_id;
        r.lookup_succ = tbl_id[0];
      end else begin
        found = 0;
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (!found) begin
            r.lookup_pred = tbl_id[i];
            if (i + 1 == tbl_count) begin
              r.lookup_succ = own_id;
              found = 1;
            end else if (is_between(k, tbl_id[i], tbl_id[i + 1]) || tbl_id[i + 1] == k) begin
              r.lookup_succ = tbl_id[i + 1];
              found = 1;
            end
          end
        end
      end
    end
    r.node_successor = (tbl_count != 0) ? tbl_id[0] : own_id;
    r.node_predecessor = last_entry();
    r.entry_count = tbl_count[4:0];
    return r;
  endfunction

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued words at the falling edge, predicting on acceptance.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_words.push_back(predict_table_word(in_word));
        void'(pending_words.pop_front());
        gap_left = random_gap();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() != 0) begin
          start <= 1'b1;
          in_word <= pending_words[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each strobed result word against the oldest prediction.
  always @(posedge clk) begin
    roft_pkg::out_word_t e;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %h", $time, out_word);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (e.lookup_pred !== out_word.lookup_pred)
          $display("%0t: lookup_pred expected %h actual %h", $time, e.lookup_pred,
                   out_word.lookup_pred);
        if (e.lookup_succ !== out_word.lookup_succ)
          $display("%0t: lookup_succ expected %h actual %h", $time, e.lookup_succ,
                   out_word.lookup_succ);
        if (e.pred_changed !== out_word.pred_changed)
          $display("%0t: pred_changed expected %b actual %b", $time, e.pred_changed,
                   out_word.pred_changed);
        if (e.old_pred !== out_word.old_pred)
          $display("%0t: old_pred expected %h actual %h", $time, e.old_pred,
                   out_word.old_pred);
        if (e.node_successor !== out_word.node_successor)
          $display("%0t: node_successor expected %h actual %h", $time, e.node_successor,
                   out_word.node_successor);
        if (e.node_predecessor !== out_word.node_predecessor)
          $display("%0t: node_predecessor expected %h actual %h", $time,
                   e.node_predecessor, out_word.node_predecessor);
        if (e.entry_count !== out_word.entry_count)
          $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                   out_word.entry_count);
        if (e !== out_word) fail_count++;
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || words_done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic roft_pkg::in_word_t make_word(logic op, logic [31:0] k, logic [31:0] t);
    roft_pkg::in_word_t w;
    w.opcode = op;
    w.key_id = k;
    w.time_now = t;
    return w;
  endfunction

  // Ids often near a base so that refreshes and close neighbours occur.
  function automatic logic [31:0] pick_id(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return own_id;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return base + $urandom_range(0, 40);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_own_id(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    own_id = v;
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] tick;
    logic [31:0] own_values [6];
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fail_count = 0;
    gap_left = 0;
    words_done = 0;
    tbl_count = 0;
    own_id = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_id[i] = '0;
      tbl_use[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, own id, refresh, wrap, full table and ties.
    pending_words.push_back(make_word(roft_pkg::OP_LOOKUP, 32'h0, 32'h0));
    pending_words.push_back(make_word(roft_pkg::OP_INSERT, 32'h0, 32'h5));
    pending_words.push_back(make_word(roft_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(roft_pkg::OP_INSERT, 32'h8000_0000, 32'h0));
    pending_words.push_back(make_word(roft_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h7));
    pending_words.push_back(make_word(roft_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0));
    pending_words.push_back(make_word(roft_pkg::OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(roft_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0));
    for (int i = 0; i < 15; i++)
      pending_words.push_back(make_word(roft_pkg::OP_INSERT, 32'h100 * (i + 1), 32'h3));
    pending_words.push_back(make_word(roft_pkg::OP_LOOKUP, 32'h250, 32'h0));
    wait_drained();

    own_values[0] = 32'hFFFF_FFFF;
    own_values[1] = 32'h8000_0000;
    own_values[2] = $urandom();
    own_values[3] = 32'h0000_0001;
    own_values[4] = $urandom();
    own_values[5] = 32'h0;
    tick = 0;
    // Random phases, one per own id setting; the table carries over.
    for (int ph = 0; ph < 6; ph++) begin
      write_own_id(own_values[ph]);
      base = (ph % 2) ? $urandom() : own_values[ph] - 32'd20;
      for (int n = 0; n < 180; n++) begin
        case ($urandom_range(0, 9))
          0: tick = $urandom();
          1: tick = tick;
          default: tick = tick + $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 2) == 0)
          pending_words.push_back(make_word(roft_pkg::OP_LOOKUP, pick_id(base), $urandom()));
        else
          pending_words.push_back(make_word(roft_pkg::OP_INSERT, pick_id(base), tick));
      end
      wait_drained();
    end

    words_done = 1;
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/roft_pkg.sv
hw/rtl/roft_front.sv
hw/rtl/roft_engine.sv
hw/rtl/ring_ordered_finger_table_core.sv
tb/sv/tb_ring_ordered_finger_table_core.sv
